[rtl/fbpa_pkg.sv]
// Shared types, codes and constants of the fixed block pool allocator.
package fbpa_pkg;

   localparam int HANDLE_W           = 6;
   localparam int NUM_BLOCKS_DEFAULT = 32;

   localparam logic [HANDLE_W-1:0] NULL_LINK = 6'h3F;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [1:0] DIR_RX = 2'd0;
   localparam logic [1:0] DIR_TX = 2'd1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_EMPTY      = 2'd1;
   localparam logic [1:0] STATUS_BAD_DIR    = 2'd2;
   localparam logic [1:0] STATUS_BAD_HANDLE = 2'd3;

   typedef struct packed {
      logic                mode;
      logic [1:0]          direction;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [HANDLE_W-1:0] block_handle;
      logic [1:0]          status;
      logic [HANDLE_W-1:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic                en;
      logic [HANDLE_W-1:0] addr;
      logic [HANDLE_W-1:0] data;
   } link_wr_type;

endpackage

[rtl/fbpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fbpa_link_store.sv]
// Free-list link store: RAM with per-entry written bits and write-to-read bypass.
module fbpa_link_store #(
   parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fbpa_pkg::HANDLE_W-1:0] rd_addr,
   input  fbpa_pkg::link_wr_type         link_wr,
   output logic [fbpa_pkg::HANDLE_W-1:0] link
);

   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam logic [fbpa_pkg::HANDLE_W-1:0] NB_H = fbpa_pkg::HANDLE_W'(NUM_BLOCKS);
   localparam logic [fbpa_pkg::HANDLE_W-1:0] RESET_HEAD = fbpa_pkg::HANDLE_W'(NUM_BLOCKS - 1);

   logic [NUM_BLOCKS-1:0]         linked_ff, linked_in;
   logic [fbpa_pkg::HANDLE_W-1:0] rd_addr_ff;
   logic                          rd_valid_ff, rd_valid_in;
   logic                          hit_ff, hit_in;
   logic [fbpa_pkg::HANDLE_W-1:0] hit_data_ff;
   logic [fbpa_pkg::HANDLE_W-1:0] ram_q;
   logic [fbpa_pkg::HANDLE_W-1:0] reset_link;
   logic                          wr_in_range;

   fbpa_ram #(
      .WIDTH (fbpa_pkg::HANDLE_W),
      .DEPTH (NUM_BLOCKS),
      .ADDR_W(AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (link_wr.en),
      .wr_addr(link_wr.addr[AW-1:0]),
      .wr_data(link_wr.data),
      .rd_addr(rd_addr[AW-1:0]),
      .rd_data(ram_q)
   );

   assign wr_in_range = link_wr.en && (link_wr.addr < NB_H);

   always_comb begin
      linked_in = linked_ff;
      if (wr_in_range) begin
         linked_in[link_wr.addr[AW-1:0]] = 1'b1;
      end
      rd_valid_in = (rd_addr < NB_H) && linked_ff[rd_addr[AW-1:0]];
      hit_in      = link_wr.en && (link_wr.addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         linked_ff   <= '0;
         rd_addr_ff  <= RESET_HEAD;
         rd_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         linked_ff   <= linked_in;
         rd_addr_ff  <= rd_addr;
         rd_valid_ff <= rd_valid_in;
         hit_ff      <= hit_in;
      end
      hit_data_ff <= link_wr.data;
   end

   // An entry never written still holds its power-on chain link to the next lower block.
   assign reset_link = (rd_addr_ff == '0) ? fbpa_pkg::NULL_LINK
                                          : rd_addr_ff - fbpa_pkg::HANDLE_W'(1);

   always_comb begin
      priority if (hit_ff) begin
         link = hit_data_ff;
      end else if (rd_valid_ff) begin
         link = ram_q;
      end else begin
         link = reset_link;
      end
   end

`ifndef SYNTHESIS
   // A same-address write must show up in the following read.
   assert property (@(posedge clock) disable iff (reset)
      (link_wr.en && link_wr.addr == rd_addr) |=> (link == $past(link_wr.data)))
      else $error("link bypass lost a same-address write");

   // Written bits are never cleared outside reset.
   assert property (@(posedge clock) disable iff (reset)
      ##1 (($past(linked_ff) & ~linked_ff) == '0))
      else $error("link written bit cleared");

   // A pool write marks its entry as written.
   assert property (@(posedge clock) disable iff (reset)
      wr_in_range |=> linked_ff[$past(link_wr.addr[AW-1:0])])
      else $error("link write did not set its written bit");
`endif

endmodule

[rtl/fbpa_engine.sv]
// Allocate and free logic with the list head, free count and in-use bits.
module fbpa_engine #(
   parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          emergency,
   input  logic                          req_valid,
   input  fbpa_pkg::req_type             req,
   input  logic [fbpa_pkg::HANDLE_W-1:0] link,
   output logic [fbpa_pkg::HANDLE_W-1:0] head_next,
   output fbpa_pkg::link_wr_type         link_wr,
   output fbpa_pkg::rsp_type             rsp
);

   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam logic [fbpa_pkg::HANDLE_W-1:0] NB_H = fbpa_pkg::HANDLE_W'(NUM_BLOCKS);
   localparam logic [fbpa_pkg::HANDLE_W-1:0] RX_RES = fbpa_pkg::HANDLE_W'(NUM_BLOCKS);
   localparam logic [fbpa_pkg::HANDLE_W-1:0] TX_RES = fbpa_pkg::HANDLE_W'(NUM_BLOCKS + 1);
   localparam logic [fbpa_pkg::HANDLE_W-1:0] RESET_HEAD = fbpa_pkg::HANDLE_W'(NUM_BLOCKS - 1);

   logic [fbpa_pkg::HANDLE_W-1:0] head_ff, head_in;
   logic [fbpa_pkg::HANDLE_W-1:0] count_ff, count_in;
   logic [NUM_BLOCKS-1:0]         in_use_ff, in_use_in;
   logic [AW-1:0]                 head_idx, handle_idx;

   assign head_idx   = head_ff[AW-1:0];
   assign handle_idx = req.handle[AW-1:0];

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      in_use_in = in_use_ff;
      link_wr   = '0;
      rsp       = '0;
      rsp.status = fbpa_pkg::STATUS_OK;
      if (req_valid) begin
         unique case (req.mode)
            fbpa_pkg::MODE_ALLOC: begin
               if (emergency) begin
                  priority if (req.direction == fbpa_pkg::DIR_RX) begin
                     rsp.granted      = 1'b1;
                     rsp.block_handle = RX_RES;
                  end else if (req.direction == fbpa_pkg::DIR_TX) begin
                     rsp.granted      = 1'b1;
                     rsp.block_handle = TX_RES;
                  end else begin
                     rsp.status = fbpa_pkg::STATUS_BAD_DIR;
                  end
               end else if (count_ff != '0 && head_ff < NB_H) begin
                  head_in             = link;
                  link_wr.en          = 1'b1;
                  link_wr.addr        = head_ff;
                  link_wr.data        = fbpa_pkg::NULL_LINK;
                  in_use_in[head_idx] = 1'b1;
                  count_in            = count_ff - fbpa_pkg::HANDLE_W'(1);
                  rsp.granted         = 1'b1;
                  rsp.block_handle    = head_ff;
               end else begin
                  rsp.status = fbpa_pkg::STATUS_EMPTY;
               end
            end
            fbpa_pkg::MODE_FREE: begin
               // Reserve handles are never pooled, so freeing one is a no-op.
               priority if (req.handle == RX_RES || req.handle == TX_RES) begin
                  rsp.status = fbpa_pkg::STATUS_OK;
               end else if (req.handle >= NB_H || !in_use_ff[handle_idx]) begin
                  rsp.status = fbpa_pkg::STATUS_BAD_HANDLE;
               end else begin
                  link_wr.en            = 1'b1;
                  link_wr.addr          = req.handle;
                  link_wr.data          = head_ff;
                  head_in               = req.handle;
                  in_use_in[handle_idx] = 1'b0;
                  count_in              = count_ff + fbpa_pkg::HANDLE_W'(1);
               end
            end
            default: begin
               rsp.status = fbpa_pkg::STATUS_OK;
            end
         endcase
      end
      rsp.free_count = count_in;
   end

   assign head_next = head_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= RESET_HEAD;
         count_ff  <= NB_H;
         in_use_ff <= '0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         in_use_ff <= in_use_in;
      end
   end

`ifndef SYNTHESIS
   // Every pool block is either on the free list or in use.
   assert property (@(posedge clock) disable iff (reset)
      count_ff == NB_H - fbpa_pkg::HANDLE_W'($countones(in_use_ff)))
      else $error("free count disagrees with in-use bits");

   // An empty pool leaves the list head at the null link.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == fbpa_pkg::NULL_LINK))
      else $error("empty pool with a live list head");

   // A pool grant takes exactly one block off the free count.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && rsp.granted && !emergency) |=>
         (count_ff + fbpa_pkg::HANDLE_W'(1) == $past(count_ff)))
      else $error("pool grant did not decrement the free count");
`endif

endmodule

[rtl/fixed_block_pool_allocator.sv]
// A request is registered, handled in the engine, and its result registered and strobed.
// Throughput: one request per cycle; the list head pop and push are computed combinationally,
// with the link RAM read for the new head addressed by the engine's next-head output.
// Reset: synchronous; reset restores the full free list without a clearing pass,
// as per-entry written bits supply the power-on links. busy is high only during reset.
// The result has no back-pressure: each result beat is valid for exactly one cycle.
module fixed_block_pool_allocator #(
   parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fbpa_pkg::req_type req_data,
   output logic              rsp_valid,
   output fbpa_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   logic                          req_valid_ff;
   fbpa_pkg::req_type             req_ff;
   logic                          rsp_valid_ff;
   fbpa_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          emergency_ff;
   logic [fbpa_pkg::HANDLE_W-1:0] head_next;
   logic [fbpa_pkg::HANDLE_W-1:0] link;
   fbpa_pkg::link_wr_type         link_wr;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         emergency_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
         if (csr_wr_en) begin
            emergency_ff <= csr_wr_data;
         end
      end
      req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   fbpa_engine #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .emergency(emergency_ff),
      .req_valid(req_valid_ff),
      .req      (req_ff),
      .link     (link),
      .head_next(head_next),
      .link_wr  (link_wr),
      .rsp      (rsp_in)
   );

   fbpa_link_store #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_link_store (
      .clock  (clock),
      .reset  (reset),
      .rd_addr(head_next),
      .link_wr(link_wr),
      .link   (link)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Every accepted request beat yields a result beat once it has passed the request and result registers.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted request produced no result");

   // No result beat appears without an accepted request ahead of it in the request and result registers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result beat without a request");

   // Only allocations can be granted.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.granted) |-> ($past(req_data.mode, 2) == fbpa_pkg::MODE_ALLOC))
      else $error("grant on a free request");
`endif

endmodule
